// File: hdl/assert_macros.svh
// Assertion macros shared by the checker files of the decimal text block.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SIDT_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SIDT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/sidt_pkg.sv
// Types and constants of the signed integer to padded decimal text block.
// Depends on nothing; used by the interfaces, the controller and the datapath.
package sidt_pkg;

   localparam int VALUE_W     = 32;
   localparam int WIDTH_W     = 6;
   localparam int CHAR_W      = 8;
   localparam int DIGITS      = 10;
   localparam int BCD_W       = 4 * DIGITS;
   localparam int ND_W        = 4;
   localparam int CONV_CYCLES = VALUE_W / 2;
   localparam int CNT_W       = $clog2(CONV_CYCLES);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic load;
      logic shift;
      logic check;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic is_err;
      logic is_last;
   } sts_type;

   // One shift-and-add-three step: correct every digit of five or more, then
   // shift the next magnitude bit in at the bottom.
   function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                     input logic bit_in);
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], bit_in};
   endfunction

endpackage

// File: hdl/sidt_if.sv
// Valid/ready channel interfaces for the request and result items.
// Depends on sidt_pkg for the field widths.
interface sidt_req_if import sidt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic        [WIDTH_W-1:0] width;

   modport source (output valid, value, width, input ready);
   modport sink   (input valid, value, width, output ready);
endinterface

interface sidt_rsp_if import sidt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;
   logic              error;

   modport source (output valid, char_code, last, error, input ready);
   modport sink   (input valid, char_code, last, error, output ready);
endinterface

// File: hdl/sidt_dpath.sv
// Datapath: magnitude register, binary to BCD converter, field checks and the
// registered result stage. Depends on sidt_pkg; driven by sidt_ctrl commands.
module sidt_dpath import sidt_pkg::*; #(
   parameter int MAX_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output sts_type                   sts,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic        [WIDTH_W-1:0] req_width,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic        [CHAR_W-1:0]  rsp_char_code,
   output logic                      rsp_last,
   output logic                      rsp_error
);

   localparam logic [WIDTH_W:0] MAX_W_VEC = (WIDTH_W + 1)'(MAX_WIDTH);

   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic               neg_ff, neg_in;
   logic [WIDTH_W-1:0] width_ff, width_in;
   logic [WIDTH_W-1:0] pos_ff, pos_in;
   logic [ND_W-1:0]    nd_ff, nd_in;
   logic               err_ff, err_in;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic               error_ff, error_in;

   logic [VALUE_W-1:0] raw;
   logic [ND_W-1:0]    nd_calc;
   logic [ND_W:0]      need;
   logic [WIDTH_W-1:0] k;
   logic [ND_W-1:0]    dig_idx;
   logic [CHAR_W-1:0]  text_char;
   logic               pos_last;

   assign raw = VALUE_W'(req_value);

   always_comb begin
      nd_calc = ND_W'(1);
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            nd_calc = ND_W'(i + 1);
         end
      end
   end

   assign need     = {1'b0, nd_calc} + {{ND_W{1'b0}}, neg_ff};
   assign pos_last = ({1'b0, pos_ff} + 1'b1) == {1'b0, width_ff};
   assign k        = pos_ff - {{(WIDTH_W-1){1'b0}}, neg_ff};
   assign dig_idx  = nd_ff - ND_W'(1) - k[ND_W-1:0];

   always_comb begin
      if (neg_ff && (pos_ff == '0)) begin
         text_char = CHAR_MINUS;
      end else if (k < {{(WIDTH_W-ND_W){1'b0}}, nd_ff}) begin
         text_char = CHAR_ZERO + {4'd0, bcd_ff[{dig_idx, 2'b00} +: 4]};
      end else begin
         text_char = CHAR_SPACE;
      end
   end

   always_comb begin
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      width_in = width_ff;
      pos_in   = pos_ff;
      nd_in    = nd_ff;
      err_in   = err_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      error_in = error_ff;
      valid_in = valid_ff && !rsp_ready;
      if (cmd.load) begin
         neg_in   = raw[VALUE_W-1];
         mag_in   = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
         width_in = req_width;
         bcd_in   = '0;
         pos_in   = '0;
      end
      if (cmd.shift) begin
         bcd_in = dabble_step(dabble_step(bcd_ff, mag_ff[VALUE_W-1]), mag_ff[VALUE_W-2]);
         mag_in = {mag_ff[VALUE_W-3:0], 2'b00};
      end
      if (cmd.check) begin
         nd_in  = nd_calc;
         err_in = (width_ff == '0) || ({1'b0, width_ff} > MAX_W_VEC)
                  || ({{(WIDTH_W-ND_W){1'b0}}, need} > {1'b0, width_ff});
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
         if (err_ff) begin
            char_in  = CHAR_NONE;
            last_in  = 1'b1;
            error_in = 1'b1;
         end else begin
            char_in  = text_char;
            last_in  = pos_last;
            error_in = 1'b0;
            pos_in   = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      bcd_ff   <= bcd_in;
      neg_ff   <= neg_in;
      width_ff <= width_in;
      pos_ff   <= pos_in;
      nd_ff    <= nd_in;
      err_ff   <= err_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
      error_ff <= error_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign sts.out_free = !valid_ff || rsp_ready;
   assign sts.is_err   = err_ff;
   assign sts.is_last  = pos_last;

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;
   assign rsp_error     = error_ff;

endmodule

// File: hdl/sidt_ctrl.sv
// Controller: sequences accept, conversion, field check and character output.
// Depends on sidt_pkg for the command and status structs.
module sidt_ctrl import sidt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CONV  = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.shift = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CONV_CYCLES - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.is_err || sts.is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/signed_int_to_padded_decimal_text.sv
// Channel  Dir  Payload                           Accepted when
// req_ch   in   value[31:0] signed, width[5:0]    req_ch.valid && req_ch.ready
// rsp_ch   out  char_code[7:0], last, error       rsp_ch.valid && rsp_ch.ready
//
// An item goes through accept, binary to BCD conversion (two bits per cycle
// in the converter), field checking, then output of its characters, or of a
// single error item when the field check fails.
// A new item is taken once the last character is in the output register.
// Synchronous reset clears the controller state and the result valid flag.
// A stalled result holds the output register and pauses the character count.
module signed_int_to_padded_decimal_text import sidt_pkg::*; #(
   parameter int MAX_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   sidt_req_if.sink   req_ch,
   sidt_rsp_if.source rsp_ch
);

   cmd_type cmd;
   sts_type sts;

   sidt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   sidt_dpath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_value     (req_ch.value),
      .req_width     (req_ch.width),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_char_code (rsp_ch.char_code),
      .rsp_last      (rsp_ch.last),
      .rsp_error     (rsp_ch.error)
   );

endmodule

// File: hdl/sidt_checker.sv
// Port-level assertions for the decimal text block, bound to the top level.
// Depends on sidt_pkg for character codes and on assert_macros.svh.
`include "assert_macros.svh"

module sidt_checker import sidt_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAR_W-1:0] rsp_char_code,
   input logic              rsp_last,
   input logic              rsp_error
);

   `SIDT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result item dropped while stalled")

   `SIDT_ASSERT_ALWAYS(a_err_form, clock, reset, !(rsp_valid && rsp_error) || (rsp_last && (rsp_char_code == CHAR_NONE)), "error item must be last with a zero character")

   `SIDT_ASSERT_ALWAYS(a_char_set, clock, reset, !(rsp_valid && !rsp_error) || (rsp_char_code == CHAR_MINUS) || (rsp_char_code == CHAR_SPACE) || ((rsp_char_code >= CHAR_ZERO) && (rsp_char_code <= CHAR_NINE)), "text item is not a sign, digit or space")

   `SIDT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "request taken while an item is being converted")

endmodule

bind signed_int_to_padded_decimal_text sidt_checker u_sidt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_char_code (rsp_ch.char_code),
   .rsp_last      (rsp_ch.last),
   .rsp_error     (rsp_ch.error)
);

// File: tb/sv/testbench.sv
// Self-checking bench for the signed integer to padded decimal text block.
// Needs sidt_pkg and the channel interfaces; predicts every character of each field
// and checks the characters that come out, in order, under random idling on both sides.
`timescale 1ns / 100ps

module testbench;
   import sidt_pkg::*;

   localparam int FIELD_MAX    = 32;
   localparam int RANDOM_ITEMS = 150;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 500;
   localparam int DRAIN_CYCLES = 60;
   localparam int TIMEOUT_NS   = 1000000;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic        [WIDTH_W-1:0] width;
      logic        [3:0]         gap;
   } number_item_t;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last;
      logic              error;
   } glyph_t;

   logic clock;
   logic reset;

   sidt_req_if req_ch ();
   sidt_rsp_if rsp_ch ();

   signed_int_to_padded_decimal_text #(.MAX_WIDTH(FIELD_MAX)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   number_item_t pending_numbers [$];
   glyph_t       expected_text [$];
   int           send_gap     = 0;
   int           stall_left   = 0;
   int           results_seen = 0;
   int           failures     = 0;

   function automatic int text_length(input logic signed [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] mag;
      int                 n;
      mag = value[VALUE_W-1] ? (0 - value) : value;
      n = 1;
      while (mag >= 32'd10) begin
         mag = mag / 32'd10;
         n++;
      end
      return n + int'(value[VALUE_W-1]);
   endfunction

   function automatic void render_field(input logic signed [VALUE_W-1:0] value,
                                        input logic [WIDTH_W-1:0] width);
      logic [VALUE_W-1:0] mag;
      logic [3:0]         digit [DIGITS];
      logic [CHAR_W-1:0]  ch;
      int                 nd;
      int                 len;
      mag = value[VALUE_W-1] ? (0 - value) : value;
      nd = 0;
      do begin
         digit[nd] = 4'(mag % 32'd10);
         mag = mag / 32'd10;
         nd++;
      end while (mag != 0);
      len = text_length(value);
      if (width == 0 || width > FIELD_MAX || len > width) begin
         expected_text.push_back('{CHAR_NONE, 1'b1, 1'b1});
         return;
      end
      for (int pos = 0; pos < width; pos++) begin
         if (value[VALUE_W-1] && pos == 0) begin
            ch = CHAR_MINUS;
         end else if (pos < len) begin
            ch = CHAR_ZERO + CHAR_W'(digit[len - 1 - pos]);
         end else begin
            ch = CHAR_SPACE;
         end
         expected_text.push_back('{ch, pos == width - 1, 1'b0});
      end
   endfunction

   task automatic add_number(input logic signed [VALUE_W-1:0] value, input int width);
      number_item_t item;
      item.value = value;
      item.width = WIDTH_W'(width);
      item.gap   = ((pending_numbers.size() / 40) % 3 == 2) ? 4'd0 : 4'($urandom_range(0, 14));
      pending_numbers.push_back(item);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            render_field(req_ch.value, req_ch.width);
            void'(pending_numbers.pop_front());
            if (pending_numbers.size() > 0) begin
               send_gap = pending_numbers[0].gap;
            end
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               req_ch.valid <= 1'b0;
               send_gap--;
            end else if (pending_numbers.size() > 0) begin
               req_ch.valid <= 1'b1;
               req_ch.value <= pending_numbers[0].value;
               req_ch.width <= pending_numbers[0].width;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      glyph_t want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual char %h last %b error %b",
                        $time, rsp_ch.char_code, rsp_ch.last, rsp_ch.error);
               failures++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_ch.char_code !== want.char_code) begin
                  $display("%0t: char_code expected %h actual %h",
                           $time, want.char_code, rsp_ch.char_code);
                  failures++;
               end
               if (rsp_ch.last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time, want.last, rsp_ch.last);
                  failures++;
               end
               if (rsp_ch.error !== want.error) begin
                  $display("%0t: error expected %b actual %b", $time, want.error, rsp_ch.error);
                  failures++;
               end
            end
            results_seen++;
            stall_left = ((results_seen / 100) % 3 == 2) ? 0 : $urandom_range(0, 14);
            if (results_seen == HOLD_AFTER) begin
               stall_left = HOLD_CYCLES;
            end
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : sequencer
      logic signed [VALUE_W-1:0] v;
      int unsigned               p;
      int                        n;
      int                        w;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      req_ch.width = '0;
      rsp_ch.ready = 1'b0;

      add_number(0, 1);
      add_number(0, 32);
      add_number(-1, 2);
      add_number(-1, 1);
      add_number(32'sh7FFFFFFF, 10);
      add_number(32'sh7FFFFFFF, 9);
      add_number(32'sh80000000, 11);
      add_number(32'sh80000000, 10);
      add_number(32'sh80000000, 32);
      add_number(123, 0);
      add_number(5, 33);
      add_number(5, 63);
      add_number(-42, 32);
      add_number(1000000000, 10);
      add_number(999999999, 9);
      add_number(-10000, 6);
      add_number(100, 3);
      add_number(100, 2);
      add_number(7, 1);
      add_number(-7, 31);
      add_number(32'sh80000000, 0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 99);
            2: begin
               p = 1;
               repeat ($urandom_range(0, 9)) p = p * 10;
               v = $urandom_range(0, 1) ? p : p - 1;
            end
            3: begin
               case ($urandom_range(0, 3))
                  0: v = 32'sh80000000;
                  1: v = 32'sh7FFFFFFF;
                  2: v = 0;
                  default: v = -1;
               endcase
            end
            default: v = $urandom_range(0, 99999);
         endcase
         if (v != 32'sh80000000 && $urandom_range(0, 1)) begin
            v = -v;
         end
         n = text_length(v);
         case ($urandom_range(0, 19))
            0, 1, 2: w = $urandom_range(0, 63);
            3, 4:    w = n - 1;
            default: w = n + $urandom_range(0, FIELD_MAX - n);
         endcase
         add_number(v, w);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_numbers.size() > 0 || req_ch.valid || expected_text.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: signed_int_to_padded_decimal_text.f
+incdir+hdl
hdl/sidt_pkg.sv
hdl/sidt_if.sv
hdl/sidt_dpath.sv
hdl/sidt_ctrl.sv
hdl/signed_int_to_padded_decimal_text.sv
hdl/sidt_checker.sv
tb/sv/testbench.sv
